// ===== sv/wqoa_pkg.sv =====
// Shared types and constants of the weighted quorum owner arbiter.
package wqoa_pkg;

    localparam int OP_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 20;
    localparam int WAIT_W   = 21;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [OP_W-1:0] {
        OP_JOIN   = 2'd0,
        OP_REPORT = 2'd1,
        OP_LEAVE  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam logic [1:0] REG_CLIENT_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_GIVEUP_DELAY   = 2'd1;
    localparam logic [1:0] REG_TAKEOVER_DELAY = 2'd2;

    localparam logic [CFG_W-1:0] CLIENT_TIMEOUT_RST = 20'd5000;

    typedef struct packed {
        logic [CFG_W-1:0] client_timeout;
        logic [CFG_W-1:0] giveup_delay;
        logic [CFG_W-1:0] takeover_delay;
    } t_cfg;

endpackage

// ===== sv/wqoa_if.sv =====
// Word channels of the arbiter: request words in, status words out.
interface wqoa_in_if;
    import wqoa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SLOT_W-1:0]   client_slot;
    logic [WEIGHT_W-1:0] weight;

    modport source (output valid, output op, output client_slot, output weight,
                    input ready);
    modport sink (input valid, input op, input client_slot, input weight,
                  output ready);
endinterface

interface wqoa_res_if;
    import wqoa_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic              granted;
    logic              owner_valid;
    logic [SLOT_W-1:0] owner_slot;
    logic              holding_off;

    modport source (output valid, output status, output granted, output owner_valid,
                    output owner_slot, output holding_off, input ready);
    modport sink (input valid, input status, input granted, input owner_valid,
                  input owner_slot, input holding_off, output ready);
endinterface

// ===== sv/wqoa_cfg.sv =====
// APB register file holding the timeout and delay settings.
module wqoa_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [wqoa_pkg::ADDR_W-1:0] paddr,
    input  logic [wqoa_pkg::DATA_W-1:0] pwdata,
    output logic [wqoa_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output wqoa_pkg::t_cfg             o_cfg
);
    import wqoa_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.client_timeout <= CLIENT_TIMEOUT_RST;
            r_cfg.giveup_delay   <= '0;
            r_cfg.takeover_delay <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_CLIENT_TIMEOUT: r_cfg.client_timeout <= pwdata[CFG_W-1:0];
                REG_GIVEUP_DELAY:   r_cfg.giveup_delay   <= pwdata[CFG_W-1:0];
                REG_TAKEOVER_DELAY: r_cfg.takeover_delay <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CLIENT_TIMEOUT: prdata = DATA_W'(r_cfg.client_timeout);
            REG_GIVEUP_DELAY:   prdata = DATA_W'(r_cfg.giveup_delay);
            REG_TAKEOVER_DELAY: prdata = DATA_W'(r_cfg.takeover_delay);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== sv/weighted_quorum_owner_arbiter.sv =====
// Top level: slot table in memory, owner election and hold-off control.
// Usage:
//   i_in carries request words (op, client_slot, weight); o_res returns one
//   status word per request (status, granted, owner_valid, owner_slot,
//   holding_off), showing the owner state after that request.
//   The APB port sets client_timeout, giveup_delay and takeover_delay; write it
//   only while no request is in flight.
// Request flow:
//   join, leave, a failed report and a report during hold-off pass S_EXEC and
//   S_DONE, which registers the status word; then the next request is taken.
//   tick and a deciding report sweep the slot memory one slot a cycle in S_SCAN
//   through the single-read weight and idle memories, then pass S_FIN and S_DONE.
//   No new request is taken before the block is back in S_IDLE.
// Reset:
//   synchronous, active low; all slots inactive, no owner, no hold-off, the
//   registers back to 5000, 0, 0. Inactive slots are masked by their active
//   flags, so the memories need no clearing pass.
// Stall:
//   a status word holds in its output register until taken; the next request
//   is still accepted and waits finished in the block until the register frees.
module weighted_quorum_owner_arbiter #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wqoa_in_if.sink                     i_in,
    wqoa_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wqoa_pkg::ADDR_W-1:0] paddr,
    input  logic [wqoa_pkg::DATA_W-1:0] pwdata,
    output logic [wqoa_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import wqoa_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW-1:0] LAST = SW'(NUM_SLOTS - 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_cfg w_cfg;

    wqoa_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    logic [WEIGHT_W-1:0] mem_wt   [NUM_SLOTS];
    logic [CFG_W-1:0]    mem_idle [NUM_SLOTS];

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [WEIGHT_W-1:0]   r_wt, n_wt;
    logic                  r_status, n_status;
    logic                  r_granted, n_granted;
    logic [NUM_SLOTS-1:0]  r_active, n_active;
    logic                  r_own_vld, n_own_vld;
    logic [SW-1:0]         r_own_idx, n_own_idx;
    logic                  r_wait_act, n_wait_act;
    logic [WAIT_W-1:0]     r_wait_cnt, n_wait_cnt;
    logic                  r_elect, n_elect;
    logic [SW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_rd_end, n_rd_end;
    logic                  r_pv, n_pv;
    logic [SW-1:0]         r_pidx, n_pidx;
    logic [SW-1:0]         r_best, n_best;
    logic [WEIGHT_W-1:0]   r_maxw, n_maxw;
    logic                  r_found, n_found;
    logic                  r_best_exp, n_best_exp;
    logic                  r_own_exp, n_own_exp;
    logic [WEIGHT_W-1:0]   r_wt_q;
    logic [CFG_W-1:0]      r_idle_q;
    logic                  r_out_vld, n_out_vld;
    logic                  r_o_status, n_o_status;
    logic                  r_o_granted, n_o_granted;
    logic                  r_o_own_vld, n_o_own_vld;
    logic [SLOT_W-1:0]     r_o_own_slot, n_o_own_slot;
    logic                  r_o_hold, n_o_hold;

    logic                  wt_we, id_we, rd_en;
    logic [SW-1:0]         wt_wa, id_wa;
    logic [WEIGHT_W-1:0]   wt_wd;
    logic [CFG_W-1:0]      id_wd;
    logic [SW-1:0]         w_sidx;
    logic                  w_inr;
    logic                  p_act, p_exp;

    assign w_sidx = SW'(r_slot);
    assign w_inr  = 32'(r_slot) < 32'(NUM_SLOTS);
    assign p_act  = r_active[r_pidx];
    assign p_exp  = p_act && (r_idle_q <= CFG_W'(1));

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_out_vld;
    assign o_res.status      = r_o_status;
    assign o_res.granted     = r_o_granted;
    assign o_res.owner_valid = r_o_own_vld;
    assign o_res.owner_slot  = r_o_own_slot;
    assign o_res.holding_off = r_o_hold;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_slot       = r_slot;
        n_wt         = r_wt;
        n_status     = r_status;
        n_granted    = r_granted;
        n_active     = r_active;
        n_own_vld    = r_own_vld;
        n_own_idx    = r_own_idx;
        n_wait_act   = r_wait_act;
        n_wait_cnt   = r_wait_cnt;
        n_elect      = r_elect;
        n_rd_idx     = r_rd_idx;
        n_rd_end     = r_rd_end;
        n_pv         = 1'b0;
        n_pidx       = r_pidx;
        n_best       = r_best;
        n_maxw       = r_maxw;
        n_found      = r_found;
        n_best_exp   = r_best_exp;
        n_own_exp    = r_own_exp;
        n_out_vld    = r_out_vld && !o_res.ready;
        n_o_status   = r_o_status;
        n_o_granted  = r_o_granted;
        n_o_own_vld  = r_o_own_vld;
        n_o_own_slot = r_o_own_slot;
        n_o_hold     = r_o_hold;
        wt_we        = 1'b0;
        wt_wa        = w_sidx;
        wt_wd        = '0;
        id_we        = 1'b0;
        id_wa        = w_sidx;
        id_wd        = '0;
        rd_en        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = t_op'(i_in.op);
                    n_slot  = i_in.client_slot;
                    n_wt    = i_in.weight;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status   = ST_OK;
                n_granted  = 1'b0;
                n_state    = S_DONE;
                n_rd_idx   = '0;
                n_rd_end   = 1'b0;
                n_found    = 1'b0;
                n_maxw     = '0;
                n_best     = '0;
                n_best_exp = 1'b0;
                n_own_exp  = 1'b0;
                n_elect    = 1'b0;
                case (r_op)
                    OP_JOIN: begin
                        if (!w_inr) begin
                            n_status = ST_FAIL;
                        end else begin
                            id_we = 1'b1;
                            id_wd = w_cfg.client_timeout;
                            if (!r_active[w_sidx]) begin
                                wt_we = 1'b1;
                            end
                            n_active[w_sidx] = 1'b1;
                        end
                    end
                    OP_REPORT: begin
                        if (!w_inr || !r_active[w_sidx]) begin
                            n_status = ST_FAIL;
                        end else begin
                            id_we = 1'b1;
                            id_wd = w_cfg.client_timeout;
                            wt_we = 1'b1;
                            wt_wd = r_wt;
                            if (!r_wait_act) begin
                                n_state = S_SCAN;
                            end
                        end
                    end
                    OP_LEAVE: begin
                        if (!w_inr || !r_active[w_sidx]) begin
                            n_status = ST_FAIL;
                        end else begin
                            n_active[w_sidx] = 1'b0;
                            if (r_own_vld && r_own_idx == w_sidx) begin
                                n_wait_act = 1'b1;
                                n_wait_cnt = WAIT_W'(w_cfg.takeover_delay);
                                n_own_vld  = 1'b0;
                                n_own_idx  = '0;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (r_wait_act) begin
                            if (r_wait_cnt <= WAIT_W'(1)) begin
                                n_wait_act = 1'b0;
                                n_wait_cnt = '0;
                                n_elect    = 1'b1;
                            end else begin
                                n_wait_cnt = r_wait_cnt - WAIT_W'(1);
                            end
                        end
                        n_state = S_SCAN;
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                rd_en  = !r_rd_end;
                n_pv   = rd_en;
                n_pidx = r_rd_idx;
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + SW'(1);
                    if (r_rd_idx == LAST) begin
                        n_rd_end = 1'b1;
                    end
                end
                if (r_pv) begin
                    if (p_act && r_wt_q > r_maxw) begin
                        n_maxw     = r_wt_q;
                        n_best     = r_pidx;
                        n_found    = 1'b1;
                        n_best_exp = p_exp && (r_op == OP_TICK);
                    end
                    if (r_op == OP_TICK) begin
                        if (p_exp) begin
                            n_active[r_pidx] = 1'b0;
                            if (r_own_vld && r_own_idx == r_pidx) begin
                                n_own_exp = 1'b1;
                            end
                        end else if (p_act) begin
                            id_we = 1'b1;
                            id_wa = r_pidx;
                            id_wd = r_idle_q - CFG_W'(1);
                        end
                    end
                    if (r_pidx == LAST) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_state = S_DONE;
                if (r_op == OP_TICK) begin
                    if (r_elect) begin
                        n_own_vld = r_found;
                        n_own_idx = r_found ? r_best : '0;
                    end
                    if ((r_elect && r_found && r_best_exp) || (!r_elect && r_own_exp)) begin
                        n_wait_act = 1'b1;
                        n_wait_cnt = WAIT_W'(w_cfg.takeover_delay);
                        n_own_vld  = 1'b0;
                        n_own_idx  = '0;
                    end
                end else if (!(r_own_vld && r_active[r_own_idx])) begin
                    n_own_vld = r_found;
                    n_own_idx = r_found ? r_best : '0;
                    n_granted = r_found && (r_best == w_sidx);
                end else if (!r_found || r_best != r_own_idx) begin
                    n_wait_act = 1'b1;
                    n_wait_cnt = WAIT_W'(w_cfg.client_timeout) + WAIT_W'(w_cfg.giveup_delay);
                    n_own_vld  = 1'b0;
                    n_own_idx  = '0;
                end else begin
                    n_granted = (r_own_idx == w_sidx);
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld    = 1'b1;
                    n_o_status   = r_status;
                    n_o_granted  = r_granted;
                    n_o_own_vld  = r_own_vld;
                    n_o_own_slot = r_own_vld ? SLOT_W'(r_own_idx) : '0;
                    n_o_hold     = r_wait_act;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_active   <= '0;
            r_own_vld  <= 1'b0;
            r_own_idx  <= '0;
            r_wait_act <= 1'b0;
            r_wait_cnt <= '0;
            r_elect    <= 1'b0;
            r_rd_idx   <= '0;
            r_rd_end   <= 1'b0;
            r_pv       <= 1'b0;
            r_found    <= 1'b0;
            r_best_exp <= 1'b0;
            r_own_exp  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_own_vld  <= n_own_vld;
            r_own_idx  <= n_own_idx;
            r_wait_act <= n_wait_act;
            r_wait_cnt <= n_wait_cnt;
            r_elect    <= n_elect;
            r_rd_idx   <= n_rd_idx;
            r_rd_end   <= n_rd_end;
            r_pv       <= n_pv;
            r_found    <= n_found;
            r_best_exp <= n_best_exp;
            r_own_exp  <= n_own_exp;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_wt         <= n_wt;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_pidx       <= n_pidx;
        r_best       <= n_best;
        r_maxw       <= n_maxw;
        r_o_status   <= n_o_status;
        r_o_granted  <= n_o_granted;
        r_o_own_vld  <= n_o_own_vld;
        r_o_own_slot <= n_o_own_slot;
        r_o_hold     <= n_o_hold;
    end

    always_ff @(posedge i_clk) begin
        if (wt_we) begin
            mem_wt[wt_wa] <= wt_wd;
        end
        if (rd_en) begin
            r_wt_q <= mem_wt[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            mem_idle[id_wa] <= id_wd;
        end
        if (rd_en) begin
            r_idle_q <= mem_idle[r_rd_idx];
        end
    end

`ifndef SYNTHESIS
    a_owner_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_own_vld && r_wait_act))
        else $error("owner chosen while hold-off runs");

    a_owner_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_own_vld && r_state != S_SCAN && r_state != S_FIN) |-> r_active[r_own_idx])
        else $error("owner slot not active");

    a_wait_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_wait_act |-> (r_wait_cnt == '0))
        else $error("hold-off count left over");

    a_sweep_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> (r_rd_end && !r_pv))
        else $error("sweep finished early");

    a_word_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |=> (r_out_vld && $stable(r_o_status)))
        else $error("status word dropped under stall");
`endif

endmodule

// ===== tb/sv/tb_weighted_quorum_owner_arbiter.sv =====
// Testbench of the quorum owner arbiter: directed and random request words, predicted results.
`timescale 1ns / 1ps

module tb_weighted_quorum_owner_arbiter;
    import wqoa_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_TAIL = NUM_SLOTS + 8;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic              status;
        logic              granted;
        logic              owner_valid;
        logic [SLOT_W-1:0] owner_slot;
        logic              holding_off;
    } t_status_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    wqoa_in_if  in_if ();
    wqoa_res_if res_if ();

    weighted_quorum_owner_arbiter #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predicted arbiter state
    logic [CFG_W-1:0]    arb_timeout;
    logic [CFG_W-1:0]    arb_giveup;
    logic [CFG_W-1:0]    arb_takeover;
    logic                tab_active [NUM_SLOTS];
    logic [WEIGHT_W-1:0] tab_weight [NUM_SLOTS];
    logic [CFG_W-1:0]    tab_idle   [NUM_SLOTS];
    logic                own_valid;
    logic [SLOT_W-1:0]   own_slot;
    logic                hold_active;
    logic [WAIT_W-1:0]   hold_count;

    t_status_word pending_status [$];
    t_idle_mode   idle_mode = IDLE_NONE;

    int n_words    = 0;
    int n_checked  = 0;
    int n_fail     = 0;
    int n_grants   = 0;
    int n_held     = 0;
    int n_expiries = 0;

    int hold_len   = 0;
    int hold_seq   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int quiet_cycles = 0;

    function automatic void reset_model();
        arb_timeout  = CLIENT_TIMEOUT_RST;
        arb_giveup   = '0;
        arb_takeover = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tab_active[i] = 1'b0;
            tab_weight[i] = '0;
            tab_idle[i]   = '0;
        end
        own_valid   = 1'b0;
        own_slot    = '0;
        hold_active = 1'b0;
        hold_count  = '0;
    endfunction

    function automatic logic best_slot(output logic [SLOT_W-1:0] idx);
        logic [WEIGHT_W-1:0] top;
        logic                found;
        top   = '0;
        found = 1'b0;
        idx   = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tab_active[i] && tab_weight[i] > top) begin
                top   = tab_weight[i];
                idx   = SLOT_W'(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void begin_hold(logic [WAIT_W-1:0] len);
        hold_active = 1'b1;
        hold_count  = len;
        own_valid   = 1'b0;
        own_slot    = '0;
    endfunction

    function automatic void release_slot(logic [SLOT_W-1:0] s);
        tab_active[s] = 1'b0;
        tab_weight[s] = '0;
        tab_idle[s]   = '0;
        if (own_valid && own_slot == s) begin
            begin_hold(WAIT_W'(arb_takeover));
        end
    endfunction

    function automatic void reelect();
        logic [SLOT_W-1:0] b;
        own_valid = best_slot(b);
        own_slot  = own_valid ? b : '0;
    endfunction

    function automatic logic decide_grant(logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] b;
        logic              have;
        logic              cur_ok;
        if (hold_active) begin
            return 1'b0;
        end
        have   = best_slot(b);
        cur_ok = own_valid && tab_active[own_slot];
        if (!cur_ok) begin
            own_valid = have;
            own_slot  = have ? b : '0;
        end else if (!have || b != own_slot) begin
            begin_hold(WAIT_W'(arb_timeout) + WAIT_W'(arb_giveup));
            return 1'b0;
        end
        return own_valid && own_slot == s;
    endfunction

    function automatic t_status_word predict_status(t_op kind, logic [SLOT_W-1:0] s,
                                                    logic [WEIGHT_W-1:0] w);
        t_status_word res;
        res = '0;
        res.status = ST_OK;
        case (kind)
            OP_JOIN: begin
                if (!tab_active[s]) begin
                    tab_active[s] = 1'b1;
                    tab_weight[s] = '0;
                end
                tab_idle[s] = arb_timeout;
            end
            OP_REPORT: begin
                if (!tab_active[s]) begin
                    res.status = ST_FAIL;
                end else begin
                    tab_idle[s]   = arb_timeout;
                    tab_weight[s] = w;
                    res.granted   = decide_grant(s);
                end
            end
            OP_LEAVE: begin
                if (!tab_active[s]) begin
                    res.status = ST_FAIL;
                end else begin
                    release_slot(s);
                end
            end
            OP_TICK: begin
                if (hold_active) begin
                    if (hold_count <= 1) begin
                        hold_active = 1'b0;
                        hold_count  = '0;
                        reelect();
                    end else begin
                        hold_count--;
                    end
                end
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (tab_active[i]) begin
                        if (tab_idle[i] <= 1) begin
                            release_slot(SLOT_W'(i));
                            n_expiries++;
                        end else begin
                            tab_idle[i]--;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.owner_valid = own_valid;
        res.owner_slot  = own_valid ? own_slot : '0;
        res.holding_off = hold_active;
        return res;
    endfunction

    function automatic bit coin(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic int send_idle_pct();
        case (idle_mode)
            IDLE_SENDER: return 72;
            IDLE_BOTH:   return 17;
            default:     return 0;
        endcase
    endfunction

    function automatic int stall_pct();
        case (idle_mode)
            IDLE_RECEIVER: return 72;
            IDLE_BOTH:     return 17;
            default:       return 0;
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        logic [SLOT_W-1:0] live [$];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tab_active[i]) begin
                live.push_back(SLOT_W'(i));
            end
        end
        if (live.size() != 0 && coin(80)) begin
            return live[$urandom_range(0, live.size() - 1)];
        end
        return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return WEIGHT_W'($urandom_range(1, 4));
            2:       return WEIGHT_W'($urandom);
            default: return '1;
        endcase
    endfunction

    task automatic cmp_field(string name, logic [SLOT_W-1:0] want, logic [SLOT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic check_status_word();
        t_status_word want;
        if (pending_status.size() == 0) begin
            $error("status word arrived with nothing expected");
            n_fail++;
            return;
        end
        want = pending_status.pop_front();
        n_checked++;
        if (want.granted) n_grants++;
        if (want.holding_off) n_held++;
        cmp_field("status", want.status, res_if.status);
        cmp_field("granted", want.granted, res_if.granted);
        cmp_field("owner_valid", want.owner_valid, res_if.owner_valid);
        cmp_field("owner_slot", want.owner_slot, res_if.owner_slot);
        cmp_field("holding_off", want.holding_off, res_if.holding_off);
    endtask

    // Status word sink: check, then choose ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            check_status_word();
        end
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !coin(stall_pct());
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(t_op kind, logic [SLOT_W-1:0] slot, logic [WEIGHT_W-1:0] w);
        while (coin(send_idle_pct())) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= kind;
        in_if.client_slot <= slot;
        in_if.weight      <= w;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        pending_status.push_back(predict_status(kind, slot, w));
        n_words++;
    endtask

    task automatic settle_block(int tail);
        in_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CLIENT_TIMEOUT: arb_timeout  = val;
            REG_GIVEUP_DELAY:   arb_giveup   = val;
            REG_TAKEOVER_DELAY: arb_takeover = val;
            default: ;
        endcase
    endtask

    task automatic set_delays(logic [CFG_W-1:0] tmo, logic [CFG_W-1:0] giveup,
                              logic [CFG_W-1:0] takeover);
        settle_block(SETTLE_TAIL);
        write_reg(REG_CLIENT_TIMEOUT, tmo);
        write_reg(REG_GIVEUP_DELAY, giveup);
        write_reg(REG_TAKEOVER_DELAY, takeover);
    endtask

    task automatic random_words(int count);
        int   roll;
        t_op  kind;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 20) kind = OP_JOIN;
            else if (roll < 60) kind = OP_REPORT;
            else if (roll < 70) kind = OP_LEAVE;
            else kind = OP_TICK;
            send_word(kind, pick_slot(), pick_weight());
        end
    endtask

    task automatic test_directed_cases();
        idle_mode = IDLE_NONE;
        send_word(OP_REPORT, 4'd3, 16'h1234);
        send_word(OP_LEAVE, 4'd3, 16'h0000);
        send_word(OP_TICK, 4'hF, 16'hFFFF);
        send_word(OP_JOIN, 4'd0, 16'h0000);
        send_word(OP_JOIN, 4'd15, 16'h0000);
        send_word(OP_REPORT, 4'd15, 16'h0000);
        send_word(OP_REPORT, 4'd0, 16'hFFFF);
        send_word(OP_REPORT, 4'd15, 16'hFFFF);
        send_word(OP_JOIN, 4'd0, 16'h0000);
        send_word(OP_LEAVE, 4'd0, 16'h0000);
        send_word(OP_REPORT, 4'd15, 16'h0001);
        send_word(OP_TICK, 4'd0, 16'h0000);
        set_delays(20'd1, 20'd1, 20'd2);
        send_word(OP_JOIN, 4'd7, 16'h0000);
        send_word(OP_REPORT, 4'd7, 16'h0000);
        send_word(OP_REPORT, 4'd15, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_REPORT, 4'd15, 16'h8000);
        send_word(OP_JOIN, 4'd2, 16'h0000);
        send_word(OP_REPORT, 4'd2, 16'h8001);
        send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_REPORT, 4'd15, 16'h00FF);
        send_word(OP_TICK, 4'd0, 16'h0000);
        send_word(OP_TICK, 4'd0, 16'h0000);
    endtask

    task automatic run_phase(t_idle_mode mode, logic [CFG_W-1:0] tmo,
                             logic [CFG_W-1:0] giveup, logic [CFG_W-1:0] takeover,
                             int count);
        set_delays(tmo, giveup, takeover);
        idle_mode = mode;
        random_words(count);
    endtask

    task automatic test_register_settings();
        run_phase(IDLE_NONE, CLIENT_TIMEOUT_RST, 20'd0, 20'd0, 190);
        run_phase(IDLE_SENDER, 20'd3, 20'd2, 20'd1, 190);
        run_phase(IDLE_RECEIVER, 20'd0, 20'd0, 20'd0, 190);
        run_phase(IDLE_BOTH, '1, '1, '1, 190);
        run_phase(IDLE_NONE, CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 4)),
                  CFG_W'($urandom_range(0, 4)), 190);
        run_phase(IDLE_SENDER, CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 4)),
                  CFG_W'($urandom_range(0, 4)), 190);
        run_phase(IDLE_RECEIVER, CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 4)),
                  CFG_W'($urandom_range(0, 4)), 190);
        run_phase(IDLE_BOTH, CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(0, 4)),
                  CFG_W'($urandom_range(0, 4)), 190);
    endtask

    task automatic test_output_backpressure();
        set_delays(20'd4, 20'd1, 20'd2);
        idle_mode = IDLE_NONE;
        hold_len  = 300;
        hold_seq++;
        random_words(40);
    endtask

    task automatic test_drain_pause();
        idle_mode = IDLE_BOTH;
        random_words(30);
        settle_block(0);
        random_words(30);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.op          <= OP_JOIN;
        in_if.client_slot <= '0;
        in_if.weight      <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_register_settings();
        test_output_backpressure();
        test_drain_pause();

        idle_mode = IDLE_NONE;
        settle_block(SETTLE_TAIL);
        $display("Covered %0d request words, %0d status words checked, ten delay settings",
                 n_words, n_checked);
        $display("with %0d grants, %0d words under hold-off and %0d slot expiries",
                 n_grants, n_held, n_expiries);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
